@@ hw/rtl/fqr_pkg.sv @@
// shared types, constants and helpers for the fifo queue with remove by id
`default_nettype none

package fqr_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_BITS = 16;

  // field widths
  localparam int ID_W       = 16;
  localparam int HDL_W      = 16;
  localparam int IDX_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;
  localparam int SLOT_HDL_W = (HANDLE_BITS < HDL_W) ? HANDLE_BITS : HDL_W;

  // operation codes
  typedef enum logic [1:0] {
    MODE_ENQ    = 2'd0,
    MODE_DEQ    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NOP    = 2'd3
  } fqr_mode_t;

  // input transaction
  typedef struct packed {
    fqr_mode_t         mode;
    logic [ID_W-1:0]   item_id;
    logic [HDL_W-1:0]  item_handle;
  } fqr_in_t;

  // result transaction
  typedef struct packed {
    logic              ok;
    logic              front_valid;
    logic [ID_W-1:0]   front_id;
    logic [HDL_W-1:0]  front_handle;
    logic [CNT_W-1:0]  entry_count;
  } fqr_out_t;

  // one stored slot
  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [SLOT_HDL_W-1:0] handle;
  } fqr_entry_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FRONT,
    ST_RESP
  } fqr_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;
    logic walk;
    logic shift;
    logic begin_shift;
    logic end_remove;
    logic read_front;
    logic load_out;
  } fqr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic match;
    logic walk_end;
    logic out_free;
  } fqr_sts_t;

  // slot index of queue position pos, counted from head
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] pos);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(pos);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fqr_ctrl.sv @@
// controller state machine for the fifo queue with remove by id
`default_nettype none

module fqr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire fqr_pkg::fqr_mode_t in_mode,
  output logic                   in_stall,
  input  wire fqr_pkg::fqr_sts_t sts,
  output fqr_pkg::fqr_cmd_t      cmd
);

  fqr_pkg::fqr_state_t state_r;
  fqr_pkg::fqr_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fqr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fqr_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == fqr_pkg::MODE_REMOVE) begin
            state_nxt = fqr_pkg::ST_SCAN;
          end else begin
            state_nxt = fqr_pkg::ST_FRONT;
          end
        end
      end
      fqr_pkg::ST_SCAN: begin
        if (sts.match) begin
          state_nxt = fqr_pkg::ST_SHIFT;
        end else if (sts.walk_end) begin
          state_nxt = fqr_pkg::ST_FRONT;
        end
      end
      fqr_pkg::ST_SHIFT: begin
        if (sts.walk_end) begin
          state_nxt = fqr_pkg::ST_FRONT;
        end
      end
      fqr_pkg::ST_FRONT: begin
        state_nxt = fqr_pkg::ST_RESP;
      end
      fqr_pkg::ST_RESP: begin
        if (sts.out_free) begin
          state_nxt = fqr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fqr_pkg::ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      fqr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      fqr_pkg::ST_SCAN: begin
        cmd.walk        = 1'b1;
        cmd.begin_shift = sts.match;
      end
      fqr_pkg::ST_SHIFT: begin
        cmd.walk       = 1'b1;
        cmd.shift      = 1'b1;
        cmd.end_remove = sts.walk_end;
      end
      fqr_pkg::ST_FRONT: begin
        cmd.read_front = 1'b1;
      end
      fqr_pkg::ST_RESP: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/fqr_dpath.sv @@
// datapath: slot memory, head and count, search walker and result register
`default_nettype none

module fqr_dpath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fqr_pkg::fqr_in_t  in_data,
  input  wire fqr_pkg::fqr_cmd_t cmd,
  output fqr_pkg::fqr_sts_t      sts,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output fqr_pkg::fqr_out_t      out_data
);

  fqr_pkg::fqr_entry_t mem [fqr_pkg::QUEUE_DEPTH];
  fqr_pkg::fqr_entry_t rd_q_r;

  logic [fqr_pkg::IDX_W-1:0] head_r;
  logic [fqr_pkg::CNT_W-1:0] count_r;
  logic [fqr_pkg::CNT_W-1:0] pos_r;
  logic [fqr_pkg::CNT_W-1:0] rd_pos_r;
  logic [fqr_pkg::CNT_W-1:0] dst_r;
  logic                      rd_v_r;
  logic [fqr_pkg::ID_W-1:0]  key_r;
  logic                      ok_r;
  logic                      out_valid_r;
  fqr_pkg::fqr_out_t         out_data_r;

  logic                      not_full;
  logic                      not_empty;
  logic                      pos_live;
  logic                      do_enq;
  logic                      do_deq;
  logic                      mem_we;
  logic [fqr_pkg::IDX_W-1:0] mem_wa;
  fqr_pkg::fqr_entry_t       mem_wd;
  logic                      mem_re;
  logic [fqr_pkg::IDX_W-1:0] mem_ra;
  fqr_pkg::fqr_entry_t       enq_entry;

  assign not_full  = (count_r < fqr_pkg::CNT_W'(fqr_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pos_live  = (pos_r < count_r);
  assign do_enq    = cmd.take && (in_data.mode == fqr_pkg::MODE_ENQ) && not_full;
  assign do_deq    = cmd.take && (in_data.mode == fqr_pkg::MODE_DEQ) && not_empty;

  assign enq_entry.id     = in_data.item_id;
  assign enq_entry.handle = in_data.item_handle[fqr_pkg::SLOT_HDL_W-1:0];

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = fqr_pkg::slot_of(head_r, count_r);
    mem_wd = enq_entry;
    if (do_enq) begin
      mem_we = 1'b1;
    end else if (cmd.shift && rd_v_r) begin
      mem_we = 1'b1;
      mem_wa = fqr_pkg::slot_of(head_r, dst_r);
      mem_wd = rd_q_r;
    end
  end

  always_comb begin
    mem_re = cmd.read_front || (cmd.walk && pos_live);
    mem_ra = cmd.read_front ? head_r : fqr_pkg::slot_of(head_r, pos_r);
  end

  // slot memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q_r <= mem[mem_ra];
    end
  end

  // status to the controller
  assign sts.match    = rd_v_r && (rd_q_r.id == key_r);
  assign sts.walk_end = !rd_v_r && !pos_live;
  assign sts.out_free = !out_valid_r || !out_stall;

  // queue pointers and walker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      rd_v_r  <= 1'b0;
      pos_r   <= '0;
    end else begin
      if (cmd.take) begin
        pos_r  <= '0;
        rd_v_r <= 1'b0;
        if (do_enq) begin
          count_r <= count_r + fqr_pkg::CNT_W'(1);
        end
        if (do_deq) begin
          head_r  <= fqr_pkg::slot_of(head_r, fqr_pkg::CNT_W'(1));
          count_r <= count_r - fqr_pkg::CNT_W'(1);
        end
      end else if (cmd.begin_shift) begin
        pos_r  <= rd_pos_r + fqr_pkg::CNT_W'(1);
        rd_v_r <= 1'b0;
      end else if (cmd.walk) begin
        rd_v_r <= pos_live;
        if (pos_live) begin
          pos_r <= pos_r + fqr_pkg::CNT_W'(1);
        end
      end
      if (cmd.end_remove) begin
        count_r <= count_r - fqr_pkg::CNT_W'(1);
      end
    end
  end

  // walker payload, search key and status flag
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      key_r <= in_data.item_id;
      ok_r  <= do_enq || do_deq;
    end
    if (cmd.end_remove) begin
      ok_r <= 1'b1;
    end
    if (cmd.walk && pos_live) begin
      rd_pos_r <= pos_r;
    end
    if (cmd.begin_shift) begin
      dst_r <= rd_pos_r;
    end else if (cmd.shift && rd_v_r) begin
      dst_r <= dst_r + fqr_pkg::CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.ok          <= ok_r;
      out_data_r.front_valid <= not_empty;
      out_data_r.front_id    <= not_empty ? rd_q_r.id : '0;
      out_data_r.front_handle <= not_empty ? fqr_pkg::HDL_W'(rd_q_r.handle) : '0;
      out_data_r.entry_count <= count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/fifo_queue_with_remove_by_id.sv @@
// top level of the fifo queue with remove by id
//
// Bounded queue of up to 16 entries, each a 16-bit id with a 16-bit handle.
// Every input transaction (enqueue, dequeue, remove by id, or no-op) returns
// exactly one result with the ok flag, the front entry (zero when empty) and
// the entry count after the operation. Items are handled one at a time: a new
// transaction is accepted only after the previous result has been loaded into
// the result register. A remove uses the single read port of the slot memory
// to walk the entries in one pass, comparing ids up to the match and then
// moving each later entry one place forward. The result register lets the next
// transaction start while a result is still stalled, until the following
// result is ready. No clearing pass is needed after reset.
`default_nettype none

module fifo_queue_with_remove_by_id (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire fqr_pkg::fqr_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output fqr_pkg::fqr_out_t     out_data
);

  fqr_pkg::fqr_cmd_t cmd;
  fqr_pkg::fqr_sts_t sts;

  // controller
  fqr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  fqr_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // count never exceeds the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.entry_count <= fqr_pkg::CNT_W'(fqr_pkg::QUEUE_DEPTH)))
    else $error("entry count above queue depth");

  // front valid agrees with the count
  a_front_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.front_valid == (out_data.entry_count != '0)))
    else $error("front valid disagrees with entry count");

  // an accepted transaction keeps the block busy the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

endmodule

`default_nettype wire
